[rtl/core/vrp_pkg.sv]
// Shared widths, register indexes, trig table and fixed-point helpers for
// vertex_rotate_project. No dependencies.
package vrp_pkg;

   localparam int CoordW  = 12;
   localparam int AngleW  = 16;
   localparam int CfgW    = 10;
   localparam int ScreenW = 16;
   localparam int DepthW  = 13;
   localparam int CsrIdxW = 2;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_FOCAL    = 2'd0,
      CSR_SCALE    = 2'd1,
      CSR_CENTER_X = 2'd2,
      CSR_CENTER_Y = 2'd3
   } csr_index_type;

   localparam logic [CfgW-1:0] FocalReset   = 10'd192;
   localparam logic [CfgW-1:0] ScaleReset   = 10'd192;
   localparam logic [CfgW-1:0] CenterXReset = 10'd128;
   localparam logic [CfgW-1:0] CenterYReset = 10'd108;

   // 92 * 360: moves any 16-bit angle to a positive value with the same residue
   localparam logic [16:0] AngleBias = 17'd33120;
   // floor(u / 15) for u < 2^17
   localparam logic [17:0] Div15Mul   = 18'd139811;
   // floor(t / 24) for t < 2^13
   localparam logic [13:0] Div24Mul   = 14'd10923;
   // floor(m / 100) for m < 2^19
   localparam logic [19:0] Div100Mul  = 20'd671089;

   // cosine * 100 for angle = 15 * idx degrees
   function automatic logic signed [7:0] trig_lookup(input logic [4:0] idx);
      logic signed [7:0] v;
      case (idx)
         5'd0:  v = 8'sd100;
         5'd1:  v = 8'sd97;
         5'd2:  v = 8'sd87;
         5'd3:  v = 8'sd71;
         5'd4:  v = 8'sd50;
         5'd5:  v = 8'sd26;
         5'd6:  v = 8'sd0;
         5'd7:  v = -8'sd26;
         5'd8:  v = -8'sd50;
         5'd9:  v = -8'sd71;
         5'd10: v = -8'sd87;
         5'd11: v = -8'sd97;
         5'd12: v = -8'sd100;
         5'd13: v = -8'sd97;
         5'd14: v = -8'sd87;
         5'd15: v = -8'sd71;
         5'd16: v = -8'sd50;
         5'd17: v = -8'sd26;
         5'd18: v = 8'sd0;
         5'd19: v = 8'sd26;
         5'd20: v = 8'sd50;
         5'd21: v = 8'sd71;
         5'd22: v = 8'sd87;
         5'd23: v = 8'sd97;
         default: v = 8'sd0;
      endcase
      return v;
   endfunction

   // t mod 24, where t = floor(angle / 15)
   function automatic logic [4:0] sector_index(input logic [12:0] t);
      logic [26:0] p;
      logic [7:0]  q;
      logic [12:0] r;
      p = 27'(t) * 27'(Div24Mul);
      q = p[25:18];
      r = t - ((13'(q) << 4) + (13'(q) << 3));
      return r[4:0];
   endfunction

   // sine index: (idx - 6) mod 24
   function automatic logic [4:0] sine_index(input logic [4:0] idx);
      return (idx >= 5'd6) ? 5'(idx - 5'd6) : 5'(idx + 5'd18);
   endfunction

   // magnitude / 100 with the sign put back: truncation toward zero
   function automatic logic signed [13:0] div100(input logic [19:0] mag, input logic neg);
      logic [39:0] p;
      logic [13:0] q;
      p = 40'(mag) * 40'(Div100Mul);
      q = p[39:26];
      return neg ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic [ScreenW-1:0] sat16(input logic signed [33:0] v);
      logic [ScreenW-1:0] r;
      if (v > 34'sd32767) begin
         r = 16'h7FFF;
      end else if (v < -34'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

[rtl/core/vrp_req_if.sv]
// Input channel of vertex_rotate_project: one point and two angles per beat.
// Depends on vrp_pkg.
interface vrp_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [vrp_pkg::CoordW-1:0]   point_x;
   logic signed [vrp_pkg::CoordW-1:0]   point_y;
   logic signed [vrp_pkg::CoordW-1:0]   point_z;
   logic signed [vrp_pkg::AngleW-1:0]   angle_about_x;
   logic signed [vrp_pkg::AngleW-1:0]   angle_about_y;

   modport source (output valid, point_x, point_y, point_z, angle_about_x, angle_about_y,
                   input ready);
   modport sink   (input valid, point_x, point_y, point_z, angle_about_x, angle_about_y,
                   output ready);
endinterface

[rtl/core/vrp_rsp_if.sv]
// Result channel of vertex_rotate_project: screen position and depth per beat.
// Depends on vrp_pkg.
interface vrp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [vrp_pkg::ScreenW-1:0]  screen_x;
   logic signed [vrp_pkg::ScreenW-1:0]  screen_y;
   logic signed [vrp_pkg::DepthW-1:0]   depth;
   logic                                in_front;

   modport source (output valid, screen_x, screen_y, depth, in_front, input ready);
   modport sink   (input valid, screen_x, screen_y, depth, in_front, output ready);
endinterface

[rtl/core/vrp_csr_if.sv]
// Register write channel of vertex_rotate_project.
// Depends on vrp_pkg.
interface vrp_csr_if;
   logic                               valid;
   logic                               ready;
   logic [vrp_pkg::CsrIdxW-1:0]        index;
   logic [vrp_pkg::CfgW-1:0]           data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/vertex_rotate_project.sv]
// vertex_rotate_project: rotate a point about X then Y and project it to screen.
// Depends on vrp_pkg, vrp_req_if, vrp_rsp_if, vrp_csr_if and vrp_div.
//
// req carries one point (x, y, z) and two angles in degrees per beat; rsp
// returns one beat per request with screen x/y (saturated), depth and the
// in-front flag, in request order. csr writes focal_length, projection_scale
// and the screen origin x and y by index 0..3; it is always ready and should
// only be written while no request is in flight.
// Throughput is one beat per clock while rsp takes each beat it offers. The
// pipeline is 10 stages of angle lookup and rotation, a 20-stage
// perspective divider (one quotient bit per stage), one multiply stage, a
// 32-stage scale-down divider and the output register.
// The whole pipeline advances together: while rsp holds a beat that is not
// taken, every stage holds and req.ready is low; nothing is dropped or
// repeated. Any empty output register lets the pipe move.
// Synchronous reset empties the pipeline and loads the register defaults
// (focal 192, scale 192, center 128/108).
module vertex_rotate_project (
   input  logic       clock,
   input  logic       reset,
   vrp_req_if.sink    req,
   vrp_rsp_if.source  rsp,
   vrp_csr_if.sink    csr
);

   localparam int CW = vrp_pkg::CfgW;

   // ---------------- configuration ----------------
   logic [CW-1:0] focal_ff, scale_ff, org_x_ff, org_y_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff <= vrp_pkg::FocalReset;
         scale_ff <= vrp_pkg::ScaleReset;
         org_x_ff <= vrp_pkg::CenterXReset;
         org_y_ff <= vrp_pkg::CenterYReset;
      end else if (csr.valid) begin
         unique case (vrp_pkg::csr_index_type'(csr.index))
            vrp_pkg::CSR_FOCAL:    focal_ff <= csr.data;
            vrp_pkg::CSR_SCALE:    scale_ff <= csr.data;
            vrp_pkg::CSR_CENTER_X: org_x_ff <= csr.data;
            vrp_pkg::CSR_CENTER_Y: org_y_ff <= csr.data;
            default: ;
         endcase
      end
   end

   // ---------------- flow control ----------------
   logic out_vld_ff;
   logic en;

   assign en        = !out_vld_ff || rsp.ready;
   assign req.ready = en;

   // ---------------- stage 1: input register ----------------
   logic               s1_vld_ff;
   logic signed [11:0] s1_px_ff, s1_py_ff, s1_pz_ff;
   logic signed [15:0] s1_ax_ff, s1_ay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_px_ff <= req.point_x;
         s1_py_ff <= req.point_y;
         s1_pz_ff <= req.point_z;
         s1_ax_ff <= req.angle_about_x;
         s1_ay_ff <= req.angle_about_y;
      end
   end

   // ---------------- stage 2: angle / 15 ----------------
   logic [16:0] ux_c, uy_c;
   logic [34:0] tx_prod_c, ty_prod_c;

   assign ux_c      = {s1_ax_ff[15], s1_ax_ff} + vrp_pkg::AngleBias;
   assign uy_c      = {s1_ay_ff[15], s1_ay_ff} + vrp_pkg::AngleBias;
   assign tx_prod_c = 35'(ux_c) * 35'(vrp_pkg::Div15Mul);
   assign ty_prod_c = 35'(uy_c) * 35'(vrp_pkg::Div15Mul);

   logic               s2_vld_ff;
   logic [12:0]        s2_tx_ff, s2_ty_ff;
   logic signed [11:0] s2_px_ff, s2_py_ff, s2_pz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_tx_ff <= tx_prod_c[33:21];
         s2_ty_ff <= ty_prod_c[33:21];
         s2_px_ff <= s1_px_ff;
         s2_py_ff <= s1_py_ff;
         s2_pz_ff <= s1_pz_ff;
      end
   end

   // ---------------- stage 3: sector and table lookup ----------------
   logic [4:0] idx_x_c, idx_y_c;

   assign idx_x_c = vrp_pkg::sector_index(s2_tx_ff);
   assign idx_y_c = vrp_pkg::sector_index(s2_ty_ff);

   logic               s3_vld_ff;
   logic signed [7:0]  s3_cx_ff, s3_sx_ff, s3_cy_ff, s3_sy_ff;
   logic signed [11:0] s3_px_ff, s3_py_ff, s3_pz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_cx_ff <= vrp_pkg::trig_lookup(idx_x_c);
         s3_sx_ff <= vrp_pkg::trig_lookup(vrp_pkg::sine_index(idx_x_c));
         s3_cy_ff <= vrp_pkg::trig_lookup(idx_y_c);
         s3_sy_ff <= vrp_pkg::trig_lookup(vrp_pkg::sine_index(idx_y_c));
         s3_px_ff <= s2_px_ff;
         s3_py_ff <= s2_py_ff;
         s3_pz_ff <= s2_pz_ff;
      end
   end

   // ---------------- stage 4: X rotation products ----------------
   logic               s4_vld_ff;
   logic signed [19:0] s4_a_ff, s4_b_ff, s4_c_ff, s4_d_ff;
   logic signed [11:0] s4_px_ff;
   logic signed [7:0]  s4_cy_ff, s4_sy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_a_ff  <= 20'(s3_py_ff) * 20'(s3_cx_ff);
         s4_b_ff  <= 20'(s3_pz_ff) * 20'(s3_sx_ff);
         s4_c_ff  <= 20'(s3_py_ff) * 20'(s3_sx_ff);
         s4_d_ff  <= 20'(s3_pz_ff) * 20'(s3_cx_ff);
         s4_px_ff <= s3_px_ff;
         s4_cy_ff <= s3_cy_ff;
         s4_sy_ff <= s3_sy_ff;
      end
   end

   // ---------------- stage 5: X rotation sums ----------------
   logic signed [20:0] sum_ry_c, sum_rz1_c, neg_ry_c, neg_rz1_c;

   assign sum_ry_c  = 21'(s4_a_ff) - 21'(s4_b_ff);
   assign sum_rz1_c = 21'(s4_c_ff) + 21'(s4_d_ff);
   assign neg_ry_c  = -sum_ry_c;
   assign neg_rz1_c = -sum_rz1_c;

   logic               s5_vld_ff;
   logic [19:0]        s5_ry_mag_ff, s5_rz1_mag_ff;
   logic               s5_ry_neg_ff, s5_rz1_neg_ff;
   logic signed [11:0] s5_px_ff;
   logic signed [7:0]  s5_cy_ff, s5_sy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (en) begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_ry_neg_ff  <= sum_ry_c[20];
         s5_rz1_neg_ff <= sum_rz1_c[20];
         s5_ry_mag_ff  <= sum_ry_c[20]  ? neg_ry_c[19:0]  : sum_ry_c[19:0];
         s5_rz1_mag_ff <= sum_rz1_c[20] ? neg_rz1_c[19:0] : sum_rz1_c[19:0];
         s5_px_ff      <= s4_px_ff;
         s5_cy_ff      <= s4_cy_ff;
         s5_sy_ff      <= s4_sy_ff;
      end
   end

   // ---------------- stage 6: X rotation / 100 ----------------
   logic               s6_vld_ff;
   logic signed [13:0] s6_ry_ff, s6_rz1_ff;
   logic signed [11:0] s6_px_ff;
   logic signed [7:0]  s6_cy_ff, s6_sy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else if (en) begin
         s6_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_ry_ff  <= vrp_pkg::div100(s5_ry_mag_ff, s5_ry_neg_ff);
         s6_rz1_ff <= vrp_pkg::div100(s5_rz1_mag_ff, s5_rz1_neg_ff);
         s6_px_ff  <= s5_px_ff;
         s6_cy_ff  <= s5_cy_ff;
         s6_sy_ff  <= s5_sy_ff;
      end
   end

   // ---------------- stage 7: Y rotation products ----------------
   logic               s7_vld_ff;
   logic signed [21:0] s7_e_ff, s7_f_ff, s7_g_ff, s7_h_ff;
   logic signed [13:0] s7_ry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
      end else if (en) begin
         s7_vld_ff <= s6_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s7_e_ff  <= 22'(s6_px_ff)  * 22'(s6_cy_ff);
         s7_f_ff  <= 22'(s6_rz1_ff) * 22'(s6_sy_ff);
         s7_g_ff  <= 22'(s6_rz1_ff) * 22'(s6_cy_ff);
         s7_h_ff  <= 22'(s6_px_ff)  * 22'(s6_sy_ff);
         s7_ry_ff <= s6_ry_ff;
      end
   end

   // ---------------- stage 8: Y rotation sums ----------------
   logic signed [22:0] sum_rx_c, sum_rz_c, neg_rx_c, neg_rz_c;

   assign sum_rx_c = 23'(s7_e_ff) + 23'(s7_f_ff);
   assign sum_rz_c = 23'(s7_g_ff) - 23'(s7_h_ff);
   assign neg_rx_c = -sum_rx_c;
   assign neg_rz_c = -sum_rz_c;

   logic               s8_vld_ff;
   logic [19:0]        s8_rx_mag_ff, s8_rz_mag_ff;
   logic               s8_rx_neg_ff, s8_rz_neg_ff;
   logic signed [13:0] s8_ry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_vld_ff <= 1'b0;
      end else if (en) begin
         s8_vld_ff <= s7_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s8_rx_neg_ff <= sum_rx_c[22];
         s8_rz_neg_ff <= sum_rz_c[22];
         s8_rx_mag_ff <= sum_rx_c[22] ? neg_rx_c[19:0] : sum_rx_c[19:0];
         s8_rz_mag_ff <= sum_rz_c[22] ? neg_rz_c[19:0] : sum_rz_c[19:0];
         s8_ry_ff     <= s7_ry_ff;
      end
   end

   // ---------------- stage 9: Y rotation / 100 ----------------
   logic               s9_vld_ff;
   logic signed [13:0] s9_rx_ff, s9_ry_ff, s9_rz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_vld_ff <= 1'b0;
      end else if (en) begin
         s9_vld_ff <= s8_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s9_rx_ff <= vrp_pkg::div100(s8_rx_mag_ff, s8_rx_neg_ff);
         s9_rz_ff <= vrp_pkg::div100(s8_rz_mag_ff, s8_rz_neg_ff);
         s9_ry_ff <= s8_ry_ff;
      end
   end

   // ---------------- stage 10: perspective operands ----------------
   logic signed [14:0] den_raw_c, den_c, den_neg_c;

   assign den_raw_c = 15'(s9_rz_ff) + $signed({5'b0, focal_ff});
   assign den_c     = (den_raw_c == 15'sd0) ? 15'sd1 : den_raw_c;
   assign den_neg_c = -den_c;

   logic               s10_vld_ff;
   logic [19:0]        s10_num_ff;
   logic [12:0]        s10_den_ff;
   logic               s10_den_neg_ff, s10_front_ff;
   logic signed [13:0] s10_rx_ff, s10_ry_ff, s10_rz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_vld_ff <= 1'b0;
      end else if (en) begin
         s10_vld_ff <= s9_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s10_num_ff     <= 20'(focal_ff) * 20'(scale_ff);
         s10_den_neg_ff <= den_c[14];
         s10_den_ff     <= den_c[14] ? den_neg_c[12:0] : den_c[12:0];
         s10_front_ff   <= (den_raw_c > 15'sd0);
         s10_rx_ff      <= s9_rx_ff;
         s10_ry_ff      <= s9_ry_ff;
         s10_rz_ff      <= s9_rz_ff;
      end
   end

   // ---------------- perspective divide ----------------
   localparam int PTagW = 14 + 14 + 14 + 1 + 1;

   logic             pdiv_vld;
   logic [19:0]      pdiv_quot;
   logic [PTagW-1:0] pdiv_tag;

   vrp_div #(.NumW(20), .DenW(13), .TagW(PTagW)) u_persp_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (s10_vld_ff),
      .in_num   (s10_num_ff),
      .in_den   (s10_den_ff),
      .in_tag   ({s10_rx_ff, s10_ry_ff, s10_rz_ff, s10_den_neg_ff, s10_front_ff}),
      .out_vld  (pdiv_vld),
      .out_quot (pdiv_quot),
      .out_tag  (pdiv_tag)
   );

   // ---------------- stage 11: coordinate * perspective ----------------
   logic signed [13:0] p_rx_c, p_ry_c, p_rz_c, p_rx_neg_c, p_ry_neg_c;
   logic               p_den_neg_c, p_front_c;
   logic [12:0]        rx_mag_c, ry_mag_c;

   assign {p_rx_c, p_ry_c, p_rz_c, p_den_neg_c, p_front_c} = pdiv_tag;
   assign p_rx_neg_c = -p_rx_c;
   assign p_ry_neg_c = -p_ry_c;
   assign rx_mag_c   = p_rx_c[13] ? p_rx_neg_c[12:0] : p_rx_c[12:0];
   assign ry_mag_c   = p_ry_c[13] ? p_ry_neg_c[12:0] : p_ry_c[12:0];

   logic [32:0] mx_prod_c, my_prod_c;

   assign mx_prod_c = 33'(rx_mag_c) * 33'(pdiv_quot);
   assign my_prod_c = 33'(ry_mag_c) * 33'(pdiv_quot);

   logic              s11_vld_ff;
   logic [31:0]       s11_mx_ff, s11_my_ff;
   logic              s11_sx_neg_ff, s11_sy_neg_ff, s11_front_ff;
   logic [12:0]       s11_depth_ff;
   logic [CW-1:0]     sdiv_c;

   assign sdiv_c = (scale_ff == '0) ? CW'(1) : scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s11_vld_ff <= 1'b0;
      end else if (en) begin
         s11_vld_ff <= pdiv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s11_mx_ff     <= mx_prod_c[31:0];
         s11_my_ff     <= my_prod_c[31:0];
         s11_sx_neg_ff <= p_rx_c[13] ^ p_den_neg_c;
         s11_sy_neg_ff <= p_ry_c[13] ^ p_den_neg_c;
         s11_depth_ff  <= p_rz_c[12:0];
         s11_front_ff  <= p_front_c;
      end
   end

   // ---------------- scale-down dividers ----------------
   localparam int XTagW = 1 + 13 + 1;

   logic             xdiv_vld, ydiv_vld;
   logic [31:0]      xdiv_quot, ydiv_quot;
   logic [XTagW-1:0] xdiv_tag;
   logic             ydiv_tag;

   vrp_div #(.NumW(32), .DenW(CW), .TagW(XTagW)) u_x_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (s11_vld_ff),
      .in_num   (s11_mx_ff),
      .in_den   (sdiv_c),
      .in_tag   ({s11_sx_neg_ff, s11_depth_ff, s11_front_ff}),
      .out_vld  (xdiv_vld),
      .out_quot (xdiv_quot),
      .out_tag  (xdiv_tag)
   );

   vrp_div #(.NumW(32), .DenW(CW), .TagW(1)) u_y_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (s11_vld_ff),
      .in_num   (s11_my_ff),
      .in_den   (sdiv_c),
      .in_tag   (s11_sy_neg_ff),
      .out_vld  (ydiv_vld),
      .out_quot (ydiv_quot),
      .out_tag  (ydiv_tag)
   );

   // ---------------- output register ----------------
   logic               f_sx_neg_c, f_front_c;
   logic [12:0]        f_depth_c;
   logic signed [33:0] qx_c, qy_c, sx_c, sy_c;

   assign {f_sx_neg_c, f_depth_c, f_front_c} = xdiv_tag;
   assign qx_c = f_sx_neg_c ? -$signed({2'b0, xdiv_quot}) : $signed({2'b0, xdiv_quot});
   assign qy_c = ydiv_tag   ? -$signed({2'b0, ydiv_quot}) : $signed({2'b0, ydiv_quot});
   assign sx_c = qx_c + $signed({24'b0, org_x_ff});
   assign sy_c = qy_c + $signed({24'b0, org_y_ff});

   logic [15:0] out_sx_ff, out_sy_ff;
   logic [12:0] out_depth_ff;
   logic        out_front_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= xdiv_vld && ydiv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_sx_ff    <= vrp_pkg::sat16(sx_c);
         out_sy_ff    <= vrp_pkg::sat16(sy_c);
         out_depth_ff <= f_depth_c;
         out_front_ff <= f_front_c;
      end
   end

   assign rsp.valid    = out_vld_ff;
   assign rsp.screen_x = $signed(out_sx_ff);
   assign rsp.screen_y = $signed(out_sy_ff);
   assign rsp.depth    = $signed(out_depth_ff);
   assign rsp.in_front = out_front_ff;

endmodule

[rtl/core/vrp_div.sv]
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// tag carried alongside. Stand-alone, no package dependency.
module vrp_div #(
   parameter int NumW = 20,
   parameter int DenW = 13,
   parameter int TagW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_vld,
   input  logic [NumW-1:0] in_num,
   input  logic [DenW-1:0] in_den,
   input  logic [TagW-1:0] in_tag,
   output logic            out_vld,
   output logic [NumW-1:0] out_quot,
   output logic [TagW-1:0] out_tag
);

   logic            vld_ff [NumW];
   logic [DenW-1:0] rem_ff [NumW];
   logic [NumW-1:0] acc_ff [NumW];
   logic [DenW-1:0] den_ff [NumW];
   logic [TagW-1:0] tag_ff [NumW];

   for (genvar i = 0; i < NumW; i++) begin : g_step
      logic            vld_prev;
      logic [DenW-1:0] rem_prev;
      logic [NumW-1:0] acc_prev;
      logic [DenW-1:0] den_prev;
      logic [TagW-1:0] tag_prev;
      logic [DenW:0]   trial;
      logic            take;

      if (i == 0) begin : g_first
         assign vld_prev = in_vld;
         assign rem_prev = '0;
         assign acc_prev = in_num;
         assign den_prev = in_den;
         assign tag_prev = in_tag;
      end else begin : g_next
         assign vld_prev = vld_ff[i-1];
         assign rem_prev = rem_ff[i-1];
         assign acc_prev = acc_ff[i-1];
         assign den_prev = den_ff[i-1];
         assign tag_prev = tag_ff[i-1];
      end

      // acc shifts the dividend out at the top and the quotient in at the bottom
      assign trial = {rem_prev, acc_prev[NumW-1]};
      assign take  = trial >= {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= take ? DenW'(trial - {1'b0, den_prev}) : trial[DenW-1:0];
            acc_ff[i] <= {acc_prev[NumW-2:0], take};
            den_ff[i] <= den_prev;
            tag_ff[i] <= tag_prev;
         end
      end
   end

   assign out_vld  = vld_ff[NumW-1];
   assign out_quot = acc_ff[NumW-1];
   assign out_tag  = tag_ff[NumW-1];

endmodule
